// ===== hdl/brb_pkg.sv =====
package brb_pkg;

  // Buffer geometry
  localparam int SLOTS      = 8;
  localparam int READERS    = 5;
  localparam int VALUE_BITS = 16;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RID_W  = (READERS > 1) ? $clog2(READERS) : 1;

  // Fixed field widths of the request and result ports
  localparam int CMD_W     = 1;
  localparam int READER_W  = 3;
  localparam int OUTCOME_W = 3;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

  // Result outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_WRITTEN_EMPTY = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_OVERWRITTEN   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_REFUSED       = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_DELIVERED     = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_NOTHING       = 3'd4;

  // One slot entry: stored value plus one read mark per reader
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [READERS-1:0]    marks;
  } entry_t;

  // Pointer and fill-bit update from the request engine
  typedef struct packed {
    logic              wr_adv;
    logic              rd_adv;
    logic [RID_W-1:0]  rid;
    logic [SLOT_W-1:0] slot;
  } ptr_upd_t;

  // Advance a slot pointer with wrap
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] n;
    if (p == SLOT_W'(SLOTS - 1)) begin
      n = '0;
    end else begin
      n = p + SLOT_W'(1);
    end
    return n;
  endfunction

endpackage

// ===== hdl/brb_slot_ram.sv =====
module brb_slot_ram (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [brb_pkg::SLOT_W-1:0]   rd_addr,
  output brb_pkg::entry_t              rd_data,
  input  logic                         wr_en,
  input  logic [brb_pkg::SLOT_W-1:0]   wr_addr,
  input  brb_pkg::entry_t              wr_data
);

  brb_pkg::entry_t mem [brb_pkg::SLOTS];
  brb_pkg::entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/brb_ptr_file.sv =====
module brb_ptr_file (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [brb_pkg::RID_W-1:0]    sel_rid,
  output logic [brb_pkg::SLOT_W-1:0]   wr_ptr,
  output logic [brb_pkg::SLOT_W-1:0]   rd_ptr,
  input  logic [brb_pkg::SLOT_W-1:0]   query_slot,
  output logic                         query_filled,
  input  brb_pkg::ptr_upd_t            upd
);

  logic [brb_pkg::SLOT_W-1:0] wr_ptr_r;
  logic [brb_pkg::SLOT_W-1:0] rd_ptr_r [brb_pkg::READERS];
  logic [brb_pkg::SLOTS-1:0]  filled_r;

  // Hold pointers and fill bits; advance on a committed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      filled_r <= '0;
      for (int i = 0; i < brb_pkg::READERS; i++) begin
        rd_ptr_r[i] <= '0;
      end
    end else begin
      if (upd.wr_adv) begin
        wr_ptr_r            <= brb_pkg::next_slot(wr_ptr_r);
        filled_r[upd.slot]  <= 1'b1;
      end
      if (upd.rd_adv) begin
        rd_ptr_r[upd.rid] <= brb_pkg::next_slot(rd_ptr_r[upd.rid]);
      end
    end
  end

  assign wr_ptr       = wr_ptr_r;
  assign rd_ptr       = rd_ptr_r[sel_rid];
  assign query_filled = filled_r[query_slot];

endmodule

// ===== hdl/broadcast_ring_buffer_unit.sv =====
// A request accepted while idle is captured, with its registered slot memory read, into the
// execute registers, and its result is then registered onto out_*. Busy stays high for the
// read-modify-write execute state, and a new request is taken only when busy is low.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low): pointers, fill bits and control clear at once;
// slot contents stay undefined until written.
module broadcast_ring_buffer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [brb_pkg::CMD_W-1:0]         in_cmd,
  input  logic [brb_pkg::READER_W-1:0]      in_reader_id,
  input  logic [brb_pkg::VALUE_BITS-1:0]    in_write_value,
  output logic                              out_strobe,
  output logic [brb_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [brb_pkg::VALUE_BITS-1:0]    out_read_value,
  output logic [brb_pkg::SLOT_W-1:0]        out_slot_index
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r;

  logic                              accept;
  logic                              rid_ok;
  logic [brb_pkg::RID_W-1:0]         rid_sel;
  logic [brb_pkg::SLOT_W-1:0]        wr_ptr;
  logic [brb_pkg::SLOT_W-1:0]        rd_ptr;
  logic [brb_pkg::SLOT_W-1:0]        slot_sel;

  // Request held for the execute cycle
  logic [brb_pkg::CMD_W-1:0]         cmd_r;
  logic [brb_pkg::RID_W-1:0]         rid_r;
  logic                              rid_ok_r;
  logic [brb_pkg::VALUE_BITS-1:0]    wval_r;
  logic [brb_pkg::SLOT_W-1:0]        slot_r;

  logic                              filled;
  brb_pkg::entry_t                   rd_entry;
  brb_pkg::entry_t                   wr_entry;
  logic                              mem_we;
  logic [brb_pkg::READERS-1:0]       rbit;
  brb_pkg::ptr_upd_t                 upd;
  logic [brb_pkg::OUTCOME_W-1:0]     outcome_nxt;
  logic [brb_pkg::VALUE_BITS-1:0]    rval_nxt;

  logic                              out_strobe_r;
  logic [brb_pkg::OUTCOME_W-1:0]     out_outcome_r;
  logic [brb_pkg::VALUE_BITS-1:0]    out_read_value_r;
  logic [brb_pkg::SLOT_W-1:0]        out_slot_index_r;

  // Select the addressed slot at accept
  assign busy    = (state_r == ST_EXEC);
  assign accept  = start && !busy;
  assign rid_ok  = (int'(in_reader_id) < brb_pkg::READERS);
  assign rid_sel = brb_pkg::RID_W'(in_reader_id);

  always_comb begin
    if (in_cmd == brb_pkg::CMD_WRITE) begin
      slot_sel = wr_ptr;
    end else if (rid_ok) begin
      slot_sel = rd_ptr;
    end else begin
      slot_sel = '0;
    end
  end

  brb_ptr_file u_ptr (
    .clk          (clk),
    .rst_n        (rst_n),
    .sel_rid      (rid_sel),
    .wr_ptr       (wr_ptr),
    .rd_ptr       (rd_ptr),
    .query_slot   (slot_r),
    .query_filled (filled),
    .upd          (upd)
  );

  brb_slot_ram u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (slot_sel),
    .rd_data (rd_entry),
    .wr_en   (mem_we),
    .wr_addr (slot_r),
    .wr_data (wr_entry)
  );

  // Decide the outcome and build the write-back
  assign rbit = brb_pkg::READERS'(1) << rid_r;

  always_comb begin
    outcome_nxt    = brb_pkg::OUT_NOTHING;
    rval_nxt       = '0;
    mem_we         = 1'b0;
    wr_entry.value = rd_entry.value;
    wr_entry.marks = rd_entry.marks | rbit;
    upd.wr_adv     = 1'b0;
    upd.rd_adv     = 1'b0;
    upd.rid        = rid_r;
    upd.slot       = slot_r;
    if (cmd_r == brb_pkg::CMD_WRITE) begin
      if (!filled || (rd_entry.marks == {brb_pkg::READERS{1'b1}})) begin
        outcome_nxt    = filled ? brb_pkg::OUT_OVERWRITTEN : brb_pkg::OUT_WRITTEN_EMPTY;
        wr_entry.value = wval_r;
        wr_entry.marks = '0;
        mem_we         = busy;
        upd.wr_adv     = busy;
      end else begin
        outcome_nxt = brb_pkg::OUT_REFUSED;
      end
    end else if (rid_ok_r && filled && ((rd_entry.marks & rbit) == '0)) begin
      outcome_nxt = brb_pkg::OUT_DELIVERED;
      rval_nxt    = rd_entry.value;
      mem_we      = busy;
      upd.rd_adv  = busy;
    end
  end

  // Hold state, captured request and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r  <= ST_EXEC;
            cmd_r    <= in_cmd;
            rid_r    <= rid_sel;
            rid_ok_r <= rid_ok;
            wval_r   <= in_write_value;
            slot_r   <= slot_sel;
          end
        end
        ST_EXEC: begin
          state_r          <= ST_IDLE;
          out_strobe_r     <= 1'b1;
          out_outcome_r    <= outcome_nxt;
          out_read_value_r <= rval_nxt;
          out_slot_index_r <= slot_r;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_outcome    = out_outcome_r;
  assign out_read_value = out_read_value_r;
  assign out_slot_index = out_slot_index_r;

  // Every accepted request gives its result strobe after the execute state
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_strobe)
    else $error("accepted request produced no result");

  // Busy is always low in the cycle after it is high
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A result only follows an execute cycle
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  // Only a delivered read carries a nonzero value
  a_value_only_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_outcome != brb_pkg::OUT_DELIVERED)) |-> (out_read_value == '0))
    else $error("nonzero read value on a result that is not a delivery");

endmodule

// ===== tb/broadcast_ring_buffer_unit_tb.sv =====
`timescale 1ns / 100ps

module broadcast_ring_buffer_unit_tb;

  localparam int RAND_N    = 1430;
  localparam int MAX_SHOWN = 10;

  // One request as presented to the block, with an optional hand-typed result
  typedef struct {
    logic [brb_pkg::CMD_W-1:0]      cmd;
    logic [brb_pkg::READER_W-1:0]   rid;
    logic [brb_pkg::VALUE_BITS-1:0] value;
    bit                             typed;
    logic [brb_pkg::OUTCOME_W-1:0]  outcome;
    logic [brb_pkg::VALUE_BITS-1:0] rval;
    logic [brb_pkg::SLOT_W-1:0]     slot;
  } ring_req_t;

  typedef struct packed {
    logic [brb_pkg::OUTCOME_W-1:0]  outcome;
    logic [brb_pkg::VALUE_BITS-1:0] value;
    logic [brb_pkg::SLOT_W-1:0]     slot;
  } ring_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [brb_pkg::CMD_W-1:0]        in_cmd;
  logic [brb_pkg::READER_W-1:0]     in_reader_id;
  logic [brb_pkg::VALUE_BITS-1:0]   in_write_value;
  logic                             out_strobe;
  logic [brb_pkg::OUTCOME_W-1:0]    out_outcome;
  logic [brb_pkg::VALUE_BITS-1:0]   out_read_value;
  logic [brb_pkg::SLOT_W-1:0]       out_slot_index;

  // Ring state mirrored by the predictor
  logic [brb_pkg::VALUE_BITS-1:0]   ring_val   [brb_pkg::SLOTS];
  bit                               ring_full  [brb_pkg::SLOTS];
  bit   [brb_pkg::READERS-1:0]      ring_marks [brb_pkg::SLOTS];
  bit   [brb_pkg::SLOT_W-1:0]       wr_ptr;
  bit   [brb_pkg::SLOT_W-1:0]       rd_ptr     [brb_pkg::READERS];

  ring_req_t    req_q[$];
  ring_result_t pending_q[$];
  int           taken_cnt;
  int           fail_cnt;
  int           shown_cnt;
  int           stored_cnt;
  int           refused_cnt;
  int           delivered_cnt;
  int           nothing_cnt;

  broadcast_ring_buffer_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_reader_id   (in_reader_id),
    .in_write_value (in_write_value),
    .out_strobe     (out_strobe),
    .out_outcome    (out_outcome),
    .out_read_value (out_read_value),
    .out_slot_index (out_slot_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance a ring pointer with wrap at the last slot
  function automatic bit [brb_pkg::SLOT_W-1:0] ring_advance(
      input bit [brb_pkg::SLOT_W-1:0] p);
    return (p == brb_pkg::SLOT_W'(brb_pkg::SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one request to the mirrored ring and return the result it gives
  function automatic ring_result_t predict_ring_result(
      input logic [brb_pkg::CMD_W-1:0] cmd,
      input logic [brb_pkg::READER_W-1:0] rid,
      input logic [brb_pkg::VALUE_BITS-1:0] wval);
    ring_result_t               r;
    bit [brb_pkg::SLOT_W-1:0]   s;
    r = '0;
    if (cmd == brb_pkg::CMD_WRITE) begin
      s = wr_ptr;
      r.slot = s;
      if (!ring_full[s] || ring_marks[s] == {brb_pkg::READERS{1'b1}}) begin
        r.outcome = ring_full[s] ? brb_pkg::OUT_OVERWRITTEN : brb_pkg::OUT_WRITTEN_EMPTY;
        ring_val[s] = wval;
        ring_full[s] = 1'b1;
        ring_marks[s] = '0;
        wr_ptr = ring_advance(s);
      end else begin
        r.outcome = brb_pkg::OUT_REFUSED;
      end
    end else if (rid >= brb_pkg::READERS) begin
      r.outcome = brb_pkg::OUT_NOTHING;
    end else begin
      s = rd_ptr[rid];
      r.slot = s;
      if (ring_full[s] && !ring_marks[s][rid]) begin
        r.outcome = brb_pkg::OUT_DELIVERED;
        r.value = ring_val[s];
        ring_marks[s][rid] = 1'b1;
        rd_ptr[rid] = ring_advance(s);
      end else begin
        r.outcome = brb_pkg::OUT_NOTHING;
      end
    end
    return r;
  endfunction

  task automatic add_req(input logic [brb_pkg::CMD_W-1:0] cmd,
                         input logic [brb_pkg::READER_W-1:0] rid,
                         input logic [brb_pkg::VALUE_BITS-1:0] value, input bit typed,
                         input logic [brb_pkg::OUTCOME_W-1:0] outcome,
                         input logic [brb_pkg::VALUE_BITS-1:0] rval,
                         input logic [brb_pkg::SLOT_W-1:0] slot);
    ring_req_t q;
    q.cmd = cmd;
    q.rid = rid;
    q.value = value;
    q.typed = typed;
    q.outcome = outcome;
    q.rval = rval;
    q.slot = slot;
    req_q.push_back(q);
  endtask

  // Capture each accepted request, then check each strobed result
  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (rst_n) begin
      if (start && !busy) begin
        want = predict_ring_result(in_cmd, in_reader_id, in_write_value);
        if (req_q[taken_cnt].typed) begin
          want.outcome = req_q[taken_cnt].outcome;
          want.value = req_q[taken_cnt].rval;
          want.slot = req_q[taken_cnt].slot;
        end
        pending_q.push_back(want);
        taken_cnt++;
      end
      if (out_strobe) begin
        got.outcome = out_outcome;
        got.value = out_read_value;
        got.slot = out_slot_index;
        if (pending_q.size() == 0) begin
          fail_cnt++;
          shown_cnt++;
          if (shown_cnt <= MAX_SHOWN) begin
            $display("unexpected result: outcome=%0d value=%h slot=%0d",
                     got.outcome, got.value, got.slot);
          end
        end else begin
          want = pending_q.pop_front();
          if (got.outcome !== want.outcome || got.value !== want.value ||
              got.slot !== want.slot) begin
            fail_cnt++;
            shown_cnt++;
            if (shown_cnt <= MAX_SHOWN) begin
              $display({"mismatch: expected outcome=%0d value=%h slot=%0d, ",
                        "got outcome=%0d value=%h slot=%0d"},
                       want.outcome, want.value, want.slot,
                       got.outcome, got.value, got.slot);
            end
          end
          case (want.outcome)
            brb_pkg::OUT_WRITTEN_EMPTY, brb_pkg::OUT_OVERWRITTEN: stored_cnt++;
            brb_pkg::OUT_REFUSED:                                 refused_cnt++;
            brb_pkg::OUT_DELIVERED:                               delivered_cnt++;
            default:                                              nothing_cnt++;
          endcase
        end
      end
    end
  end

  // Build the request list, release reset, then feed requests
  initial begin
    int idx;
    int wr_pct;
    int idle_pct;
    int guard;
    bit hold;
    logic [brb_pkg::READER_W-1:0] rid;

    start = 1'b0;
    in_cmd = brb_pkg::CMD_WRITE;
    in_reader_id = '0;
    in_write_value = '0;
    rst_n = 1'b0;
    taken_cnt = 0;
    fail_cnt = 0;
    shown_cnt = 0;
    stored_cnt = 0;
    refused_cnt = 0;
    delivered_cnt = 0;
    nothing_cnt = 0;
    wr_ptr = '0;
    for (int i = 0; i < brb_pkg::SLOTS; i++) begin
      ring_val[i] = '0;
      ring_full[i] = 1'b0;
      ring_marks[i] = '0;
    end
    for (int i = 0; i < brb_pkg::READERS; i++) begin
      rd_ptr[i] = '0;
    end

    // Empty ring, readers in and out of range
    add_req(brb_pkg::CMD_READ,  3'd0, 16'h0000, 1'b1, brb_pkg::OUT_NOTHING,
            16'h0000, 3'd0);
    add_req(brb_pkg::CMD_READ,  3'd7, 16'hFFFF, 1'b1, brb_pkg::OUT_NOTHING,
            16'h0000, 3'd0);
    add_req(brb_pkg::CMD_READ,  3'd5, 16'h0000, 1'b1, brb_pkg::OUT_NOTHING,
            16'h0000, 3'd0);
    // Value extremes into empty slots, read back by reader 0
    add_req(brb_pkg::CMD_WRITE, 3'd0, 16'h0000, 1'b1, brb_pkg::OUT_WRITTEN_EMPTY,
            16'h0000, 3'd0);
    add_req(brb_pkg::CMD_WRITE, 3'd3, 16'hFFFF, 1'b1, brb_pkg::OUT_WRITTEN_EMPTY,
            16'h0000, 3'd1);
    add_req(brb_pkg::CMD_READ,  3'd0, 16'h1111, 1'b1, brb_pkg::OUT_DELIVERED,
            16'h0000, 3'd0);
    add_req(brb_pkg::CMD_READ,  3'd0, 16'h2222, 1'b1, brb_pkg::OUT_DELIVERED,
            16'hFFFF, 3'd1);
    add_req(brb_pkg::CMD_READ,  3'd0, 16'h3333, 1'b1, brb_pkg::OUT_NOTHING,
            16'h0000, 3'd2);
    // Fill the rest of the ring and wrap the write pointer
    add_req(brb_pkg::CMD_WRITE, 3'd1, 16'h1234, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_WRITE, 3'd2, 16'h8001, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_WRITE, 3'd4, 16'h7FFE, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_WRITE, 3'd5, 16'h00FF, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_WRITE, 3'd6, 16'hFF00, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_WRITE, 3'd7, 16'h5A5A, 1'b0, '0, '0, '0);
    // Slot 0 still unread by four readers: refuse the write
    add_req(brb_pkg::CMD_WRITE, 3'd0, 16'hC3C3, 1'b1, brb_pkg::OUT_REFUSED,
            16'h0000, 3'd0);
    add_req(brb_pkg::CMD_READ,  3'd1, 16'h0000, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_READ,  3'd2, 16'h0000, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_READ,  3'd3, 16'h0000, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_READ,  3'd4, 16'h0000, 1'b0, '0, '0, '0);
    // All readers done with slot 0: overwrite it, then refuse on slot 1
    add_req(brb_pkg::CMD_WRITE, 3'd7, 16'hA5A5, 1'b1, brb_pkg::OUT_OVERWRITTEN,
            16'h0000, 3'd0);
    add_req(brb_pkg::CMD_WRITE, 3'd0, 16'h0F0F, 1'b1, brb_pkg::OUT_REFUSED,
            16'h0000, 3'd1);
    add_req(brb_pkg::CMD_READ,  3'd4, 16'h0000, 1'b0, '0, '0, '0);
    add_req(brb_pkg::CMD_READ,  3'd6, 16'h0000, 1'b1, brb_pkg::OUT_NOTHING,
            16'h0000, 3'd0);

    // Random traffic; the write share changes every 50 requests to swing the ring
    // between full and drained
    wr_pct = 40;
    for (int i = 0; i < RAND_N; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(3))
          0:       wr_pct = 15;
          1:       wr_pct = 40;
          2:       wr_pct = 60;
          default: wr_pct = 85;
        endcase
      end
      if ($urandom_range(99) < 90) begin
        rid = brb_pkg::READER_W'($urandom_range(brb_pkg::READERS - 1));
      end else begin
        rid = brb_pkg::READER_W'($urandom_range((1 << brb_pkg::READER_W) - 1,
                                                brb_pkg::READERS));
      end
      add_req(($urandom_range(99) < wr_pct) ? brb_pkg::CMD_WRITE : brb_pkg::CMD_READ,
              rid, brb_pkg::VALUE_BITS'($urandom), 1'b0, '0, '0, '0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Present requests; hold each one while busy, idle at random between them
    idx = 0;
    while (idx < req_q.size()) begin
      @(posedge clk);
      if (start && !busy) begin
        idx++;
      end
      hold = start && busy;
      if (!hold) begin
        if (idx < 23 + RAND_N / 3) begin
          idle_pct = 31;
        end else if (idx < 23 + 2 * RAND_N / 3) begin
          idle_pct = 87;
        end else begin
          idle_pct = 0;
        end
        if (idx < req_q.size() && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_cmd <= req_q[idx].cmd;
          in_reader_id <= req_q[idx].rid;
          in_write_value <= req_q[idx].value;
        end else begin
          start <= 1'b0;
        end
      end
    end

    // Drain outstanding results, then let the pipeline settle
    guard = 0;
    while (pending_q.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    if (pending_q.size() != 0) begin
      fail_cnt++;
      $display("%0d results never arrived", pending_q.size());
    end
    repeat (8) @(posedge clk);

    $display("%0d requests issued; results: %0d stored, %0d refused,",
             taken_cnt, stored_cnt, refused_cnt);
    $display("%0d delivered, %0d nothing new; %0d mismatches in total",
             delivered_cnt, nothing_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
